@@ hdl/irbsfa_pkg.sv @@
`default_nettype none
package irbsfa_pkg;

  localparam int AngleW   = 11;
  localparam int CodeW    = 8;
  localparam int StateW   = 2;
  localparam int RunW     = 2;
  localparam int AddrW    = 4;
  localparam int DataW    = 32;
  localparam int MaxAngle = 1275;

  localparam int DefSamplesPerGroup = 3;

  localparam logic [CodeW-1:0]  WeakStrengthRst = 8'd10;
  localparam logic [AngleW-1:0] JumpLimitRst    = 11'd70;
  localparam logic [RunW-1:0]   ConfirmCountRst = 2'd2;
  localparam logic [AngleW-1:0] LostLimitRst    = 11'd1000;

  // seeker states that force a zero average
  localparam logic [StateW-1:0] BallLost   = 2'd1;
  localparam logic [StateW-1:0] BallHidden = 2'd2;

  typedef enum logic [1:0] {
    REG_WEAK_STRENGTH = 2'd0,
    REG_JUMP_LIMIT    = 2'd1,
    REG_CONFIRM_COUNT = 2'd2,
    REG_LOST_LIMIT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CodeW-1:0]  first_angle;
    logic [CodeW-1:0]  first_strength;
    logic [CodeW-1:0]  second_angle;
    logic [CodeW-1:0]  second_strength;
    logic [StateW-1:0] ball_state_in;
  } in_t;

  typedef struct packed {
    logic [AngleW-1:0] average_angle;
    logic [StateW-1:0] ball_state_out;
  } out_t;

endpackage
`default_nettype wire

@@ hdl/ir_bearing_spike_filter_average_core.sv @@
// a group's last reading is registered in the input stage, its sum in the group result stage, then its result word
// is registered at the output; throughput: one reading per cycle; a result waiting on out_stall does not block
// intake until the internal result stage is also full
// reset (rst, synchronous): clears the filter state, group count and valid flags,
// and loads the register defaults
`default_nettype none
module ir_bearing_spike_filter_average_core #(
  parameter int SAMPLES_PER_GROUP = irbsfa_pkg::DefSamplesPerGroup
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [irbsfa_pkg::AddrW-1:0] paddr,
  input  wire logic [irbsfa_pkg::DataW-1:0] pwdata,
  output logic      [irbsfa_pkg::DataW-1:0] prdata,
  output logic                              pready,
  input  wire irbsfa_pkg::in_t              in_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  output irbsfa_pkg::out_t                  out_data,
  output logic                              out_valid,
  input  wire logic                         out_stall
);
  import irbsfa_pkg::*;

  localparam int N     = SAMPLES_PER_GROUP;
  localparam int IdxW  = (N > 1) ? $clog2(N) : 1;
  localparam int SumW  = $clog2(MaxAngle * N + 1);
  // reciprocal exact for all sums below 2**SumW with N up to 8
  localparam int K     = SumW + 3;
  localparam longint unsigned RecipL = ((64'd1 << K) + 64'(N) - 64'd1) / 64'(N);
  localparam logic [K:0] Recip = (K+1)'(RecipL);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(N - 1);

  // configuration
  logic [CodeW-1:0]  weak_strength;
  logic [AngleW-1:0] jump_limit;
  logic [RunW-1:0]   confirm_count;
  logic [AngleW-1:0] lost_limit;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      weak_strength <= WeakStrengthRst;
      jump_limit    <= JumpLimitRst;
      confirm_count <= ConfirmCountRst;
      lost_limit    <= LostLimitRst;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_WEAK_STRENGTH: weak_strength <= pwdata[CodeW-1:0];
        REG_JUMP_LIMIT:    jump_limit    <= pwdata[AngleW-1:0];
        REG_CONFIRM_COUNT: confirm_count <= pwdata[RunW-1:0];
        REG_LOST_LIMIT:    lost_limit    <= pwdata[AngleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_WEAK_STRENGTH: prdata = DataW'(weak_strength);
      REG_JUMP_LIMIT:    prdata = DataW'(jump_limit);
      REG_CONFIRM_COUNT: prdata = DataW'(confirm_count);
      REG_LOST_LIMIT:    prdata = DataW'(lost_limit);
      default:           prdata = '0;
    endcase
  end

  // pipeline control
  logic s1_valid;
  in_t  s1_data;
  logic s2_valid;
  logic [SumW-1:0]   s2_sum;
  logic [StateW-1:0] s2_state;
  logic out_ready, s2_ready, s1_adv, s1_last, in_acc;

  assign out_ready = !out_valid || !out_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_adv    = s1_valid && (!s1_last || s2_ready);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data <= in_data;
    end
  end

  // spike filter
  logic [AngleW-1:0] accepted_angle, accepted_angle_next;
  logic [RunW-1:0]   jump_run, jump_run_next, run_inc;
  logic [SumW-1:0]   group_sum, sum_next;
  logic [IdxW-1:0]   group_index;
  logic [CodeW-1:0]  code;
  logic [AngleW-1:0] angle, diff, filt;
  logic              jump, confirm;

  always_comb begin
    code    = (s1_data.second_strength < weak_strength) ? s1_data.first_angle
                                                       : s1_data.second_angle;
    angle   = {1'b0, code, 2'b00} + {3'b000, code};
    diff    = (angle > accepted_angle) ? angle - accepted_angle
                                       : accepted_angle - angle;
    jump    = diff > jump_limit;
    run_inc = jump_run + 2'd1;
    confirm = run_inc == confirm_count;
    filt    = (jump && !confirm) ? accepted_angle : angle;
    accepted_angle_next = filt;
    jump_run_next = (jump && !confirm) ? run_inc : '0;
    sum_next = group_sum + SumW'(filt);
    s1_last  = group_index == LastIdx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_angle <= '0;
      jump_run       <= '0;
      group_sum      <= '0;
      group_index    <= '0;
    end else if (s1_adv) begin
      accepted_angle <= accepted_angle_next;
      jump_run       <= jump_run_next;
      if (s1_last) begin
        group_sum   <= '0;
        group_index <= '0;
      end else begin
        group_sum   <= sum_next;
        group_index <= group_index + 1'b1;
      end
    end
  end

  // group result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      s2_valid <= 1'b1;
    end else if (out_ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      s2_sum   <= sum_next;
      s2_state <= s1_data.ball_state_in;
    end
  end

  // mean by reciprocal multiply, then the lost check
  logic [SumW+K:0]   prod;
  logic [AngleW-1:0] avg;
  logic [StateW-1:0] state_res;
  out_t              res;

  always_comb begin
    prod      = (SumW+K+1)'(s2_sum) * (SumW+K+1)'(Recip);
    avg       = AngleW'(prod >> K);
    state_res = (avg > lost_limit) ? BallLost : s2_state;
    res.ball_state_out = state_res;
    res.average_angle  = (state_res == BallLost || state_res == BallHidden) ? '0 : avg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid) begin
      out_data <= res;
    end
  end

`ifndef ASSERT_OFF
  a_zero_when_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.ball_state_out == BallLost ||
                  out_data.ball_state_out == BallHidden)
    |-> out_data.average_angle == '0)
    else $error("nonzero average with lost or hidden state");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    group_index <= LastIdx)
    else $error("group index past end of group");

  a_small_jump_clears: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !jump |=> jump_run == '0 && accepted_angle == $past(angle))
    else $error("small jump did not accept angle");

  a_result_only_at_end: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !s1_last |=> group_index != '0)
    else $error("group count wrapped early");
`endif

endmodule
`default_nettype wire

@@ bench/irbsfa_checker.sv @@
`default_nettype none
module irbsfa_checker #(
  parameter int SAMPLES_PER_GROUP = irbsfa_pkg::DefSamplesPerGroup
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [irbsfa_pkg::AddrW-1:0] paddr,
  input  wire logic [irbsfa_pkg::DataW-1:0] pwdata,
  input  wire logic                         pready,
  input  wire irbsfa_pkg::in_t              in_data,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire irbsfa_pkg::out_t             out_data,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  output int                                pending,
  output int                                fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import irbsfa_pkg::*;

  localparam int AngleScale = 5;
  localparam int SumW       = $clog2(MaxAngle * SAMPLES_PER_GROUP + 1);

  // register copies
  logic [CodeW-1:0]  weak_lim;
  logic [AngleW-1:0] jump_lim;
  logic [RunW-1:0]   confirm_need;
  logic [AngleW-1:0] lost_lim;

  // filter state
  logic [AngleW-1:0] held_angle;
  logic [RunW-1:0]   jump_run;
  logic [SumW-1:0]   group_sum;
  int                group_fill;

  out_t group_results_q[$];
  int   fail_cnt = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_cnt++;
  endtask

  task automatic filter_reading(input in_t r);
    logic [CodeW-1:0]  code;
    logic [AngleW-1:0] angle;
    logic [AngleW-1:0] diff;
    logic [SumW-1:0]   avg;
    out_t              res;
    code  = (r.second_strength < weak_lim) ? r.first_angle : r.second_angle;
    angle = AngleW'(int'(code) * AngleScale);
    diff  = (angle > held_angle) ? angle - held_angle : held_angle - angle;
    if (diff > jump_lim) begin
      // run counter wraps in two bits, so a zero confirm count takes four jumps
      jump_run = jump_run + 1'b1;
      if (jump_run == confirm_need) begin
        jump_run   = '0;
        held_angle = angle;
      end else begin
        angle = held_angle;
      end
    end else begin
      jump_run   = '0;
      held_angle = angle;
    end
    group_sum = group_sum + SumW'(angle);
    group_fill++;
    if (group_fill == SAMPLES_PER_GROUP) begin
      avg        = SumW'(int'(group_sum) / SAMPLES_PER_GROUP);
      group_sum  = '0;
      group_fill = 0;
      res.ball_state_out = (avg > SumW'(lost_lim)) ? BallLost : r.ball_state_in;
      if (res.ball_state_out == BallLost || res.ball_state_out == BallHidden) begin
        res.average_angle = '0;
      end else begin
        res.average_angle = avg[AngleW-1:0];
      end
      group_results_q.push_back(res);
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (group_results_q.size() == 0) begin
      report_mismatch($sformatf("result word with none expected: average %0d state %0d",
                                got.average_angle, got.ball_state_out));
      return;
    end
    want = group_results_q.pop_front();
    if (got.average_angle !== want.average_angle) begin
      report_mismatch($sformatf("average_angle %0d, expected %0d",
                                got.average_angle, want.average_angle));
    end
    if (got.ball_state_out !== want.ball_state_out) begin
      report_mismatch($sformatf("ball_state_out %0d, expected %0d",
                                got.ball_state_out, want.ball_state_out));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      weak_lim     = WeakStrengthRst;
      jump_lim     = JumpLimitRst;
      confirm_need = ConfirmCountRst;
      lost_lim     = LostLimitRst;
      held_angle   = '0;
      jump_run     = '0;
      group_sum    = '0;
      group_fill   = 0;
      group_results_q.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) filter_reading(in_data);
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[AddrW-1:2]))
          REG_WEAK_STRENGTH: weak_lim     = pwdata[CodeW-1:0];
          REG_JUMP_LIMIT:    jump_lim     = pwdata[AngleW-1:0];
          REG_CONFIRM_COUNT: confirm_need = pwdata[RunW-1:0];
          REG_LOST_LIMIT:    lost_lim     = pwdata[AngleW-1:0];
          default: ;
        endcase
      end
    end
    pending    <= group_results_q.size();
    fail_count <= fail_cnt;
  end

endmodule
`default_nettype wire

@@ bench/tb_ir_bearing_spike_filter_average_core.sv @@
`default_nettype none
module tb_ir_bearing_spike_filter_average_core;
  timeunit 1ns;
  timeprecision 1ps;
  import irbsfa_pkg::*;

  localparam int PhaseCount = 10;
  localparam int PhaseItems = 138;
  localparam int DrainPad   = 6;
  localparam int QuietLimit = 2000;

  logic              clk;
  logic              rst     = 1'b1;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [AddrW-1:0]  paddr   = '0;
  logic [DataW-1:0]  pwdata  = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  in_t               in_data  = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  out_t              out_data;
  logic              out_valid;
  logic              out_stall = 1'b0;
  int                pending;
  int                fail_count;

  // idling controls
  logic calm      = 1'b0;
  int   gap_pct   = 25;
  int   stall_pct = 6;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  // register values the stimulus is shaped around
  int cur_weak = WeakStrengthRst;
  int cur_jump = JumpLimitRst;

  ir_bearing_spike_filter_average_core i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_data(in_data), .in_valid(in_valid), .in_stall(in_stall),
    .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
  );

  irbsfa_checker i_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_data(in_data), .in_valid(in_valid), .in_stall(in_stall),
    .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall),
    .pending(pending), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || calm) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_t reading(input int a1, input int s1, input int a2, input int s2,
                                  input int st);
    in_t r;
    r.first_angle     = CodeW'(a1);
    r.first_strength  = CodeW'(s1);
    r.second_angle    = CodeW'(a2);
    r.second_strength = CodeW'(s2);
    r.ball_state_in   = StateW'(st);
    return r;
  endfunction

  task automatic send_reading(input in_t r);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every group result is back and the pipe has emptied
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainPad) @(posedge clk);
  endtask

  // leaves psel high so back-to-back writes need no idle cycle
  task automatic write_reg(input reg_idx_t idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apply_settings(input int weak_lvl, input int jump, input int confirm,
                                input int lost);
    settle();
    write_reg(REG_WEAK_STRENGTH, weak_lvl);
    write_reg(REG_JUMP_LIMIT, jump);
    write_reg(REG_CONFIRM_COUNT, confirm);
    write_reg(REG_LOST_LIMIT, lost);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    cur_weak = weak_lvl;
    cur_jump = jump;
  endtask

  initial begin
    int trend;
    int pick;
    int span;
    int code;
    int other;
    int s2;
    trend = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults: pair choice at the weak limit, spikes held and confirmed
    send_reading(reading(0, 0, 0, 0, 0));
    send_reading(reading(255, 255, 255, 9, 0));
    send_reading(reading(255, 0, 0, 10, 3));
    send_reading(reading(0, 0, 255, 255, 0));
    send_reading(reading(0, 0, 255, 200, 1));
    send_reading(reading(0, 128, 255, 255, 2));
    send_reading(reading(0, 0, 255, 255, 0));
    send_reading(reading(0, 0, 241, 255, 3));
    send_reading(reading(0, 0, 227, 255, 1));
    send_reading(reading(0, 0, 200, 255, 0));
    send_reading(reading(0, 0, 200, 255, 0));
    send_reading(reading(0, 0, 200, 255, 1));
    send_reading(reading(0, 0, 0, 255, 2));
    send_reading(reading(0, 0, 0, 255, 0));
    send_reading(reading(0, 0, 0, 255, 2));

    // run of two large jumps, then the confirm count dropped below it
    apply_settings(WeakStrengthRst, JumpLimitRst, 3, LostLimitRst);
    send_reading(reading(0, 0, 255, 255, 0));
    send_reading(reading(0, 0, 255, 255, 3));
    apply_settings(WeakStrengthRst, JumpLimitRst, 1, LostLimitRst);
    repeat (3) send_reading(reading(0, 0, 255, 255, 0));

    // zero confirm count: the fourth jump in a row is taken
    apply_settings(WeakStrengthRst, JumpLimitRst, 0, LostLimitRst);
    repeat (4) send_reading(reading(255, 0, 0, 255, 1));

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: apply_settings(0, 0, 1, 0);
        1: apply_settings(255, MaxAngle, 3, MaxAngle);
        2: apply_settings(WeakStrengthRst, JumpLimitRst, 0, LostLimitRst);
        PhaseCount - 1: apply_settings(WeakStrengthRst, JumpLimitRst, ConfirmCountRst,
                                       LostLimitRst);
        default: apply_settings($urandom_range(0, 255),
                                ($urandom_range(0, 3) == 0) ? $urandom_range(0, MaxAngle)
                                                            : $urandom_range(0, 150),
                                $urandom_range(0, 3), $urandom_range(0, MaxAngle));
      endcase
      calm      <= (ph == PhaseCount - 1);
      gap_pct   = (ph % 4) * 15;
      stall_pct <= ((ph + 1) % 4) * 4;
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          // drift around the current bearing, sometimes just past the jump limit
          span  = cur_jump / 5 + 2;
          trend = trend + int'($urandom_range(0, 2 * span)) - span;
          if (trend < 0) trend = 0;
          else if (trend > 255) trend = 255;
          code = trend;
        end else if (pick < 8) begin
          code = $urandom_range(0, 255);
        end else begin
          trend = $urandom_range(0, 255);
          code  = trend;
        end
        case ($urandom_range(0, 3))
          0:       s2 = cur_weak - 1;
          1:       s2 = cur_weak;
          default: s2 = $urandom_range(0, 255);
        endcase
        if (s2 < 0) s2 = 0;
        other = $urandom_range(0, 255);
        if (s2 < cur_weak) begin
          send_reading(reading(code, $urandom_range(0, 255), other, s2, $urandom_range(0, 3)));
        end else begin
          send_reading(reading(other, $urandom_range(0, 255), code, s2, $urandom_range(0, 3)));
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
